@@ design/rvde_pkg.sv @@
// Shared types, codes and helpers for the RV64IM decode/execute block.
`timescale 1ns / 1ps
package rvde_pkg;

    localparam int unsigned XLEN = 64;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP32   = 7'h3B;
    localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A7 = 5'd17;

    // Memory access kinds
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_ECALL   = 2'd2;

    // Back-end operations chosen by the front end
    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
        OP_OR, OP_AND, OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
        OP_MUL, OP_DIV, OP_REM, OP_PASS_A, OP_PASS_B, OP_LINK, OP_BCOND
    } t_op;

    // Classified instruction as it crosses the queue
    typedef struct packed {
        t_op         op;
        logic [2:0]  f3;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] pc;
        logic [31:0] jump_target;
        logic [31:0] branch_off;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [4:0]  dst_reg;
        logic        writes_dest;
        logic [1:0]  mem_kind;
        logic [1:0]  access_size;
        logic        load_signed;
        logic [63:0] store_data;
        logic [1:0]  status;
    } t_uop;

    // Completed result
    typedef struct packed {
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [4:0]  dst_reg;
        logic        writes_dest;
        logic [63:0] result;
        logic        taken;
        logic [31:0] next_pc;
        logic [1:0]  mem_kind;
        logic [1:0]  access_size;
        logic        load_signed;
        logic [63:0] store_data;
        logic [1:0]  status;
    } t_res;

    function automatic logic [63:0] sext32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

@@ design/rvde_decode.sv @@
// Front end: decodes an instruction into an operation and operands.
`timescale 1ns / 1ps
module rvde_decode (
    input  logic [31:0]      i_instruction,
    input  logic [31:0]      i_pc,
    input  logic [63:0]      i_src1_value,
    input  logic [63:0]      i_src2_value,
    output rvde_pkg::t_uop   o_uop
);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [4:0]  rd, rs1, rs2;
    logic [63:0] imm_i, imm_s, imm_u;
    logic [31:0] imm_b, imm_j;
    logic        bad;

    assign opc = i_instruction[6:0];
    assign f3  = i_instruction[14:12];
    assign f7  = i_instruction[31:25];
    assign f6  = i_instruction[31:26];
    assign rd  = i_instruction[11:7];
    assign rs1 = i_instruction[19:15];
    assign rs2 = i_instruction[24:20];
    assign imm_i = {{52{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_s = {{52{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
    assign imm_u = rvde_pkg::sext32({i_instruction[31:12], 12'd0});
    assign imm_b = {{20{i_instruction[31]}}, i_instruction[7], i_instruction[30:25],
                    i_instruction[11:8], 1'b0};
    assign imm_j = {{12{i_instruction[31]}}, i_instruction[19:12], i_instruction[20],
                    i_instruction[30:21], 1'b0};

    // Classification
    always_comb begin
        o_uop = '0;
        o_uop.op = rvde_pkg::OP_ADD;
        o_uop.f3 = f3;
        o_uop.a  = i_src1_value;
        o_uop.b  = i_src2_value;
        o_uop.pc = i_pc;
        o_uop.jump_target = i_pc + imm_j;
        o_uop.branch_off  = imm_b;
        o_uop.status = rvde_pkg::ST_OK;
        bad = 1'b0;
        case (opc)
            rvde_pkg::OPC_OP, rvde_pkg::OPC_OPIMM: begin
                o_uop.src1_reg = rs1;
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                if (opc == rvde_pkg::OPC_OPIMM) begin
                    o_uop.b = imm_i;
                end else begin
                    o_uop.src2_reg = rs2;
                end
                if (opc == rvde_pkg::OPC_OP && f7 == 7'h01 &&
                    (f3 == 3'd0 || f3 == 3'd4 || f3 == 3'd6)) begin
                    o_uop.op = (f3 == 3'd0) ? rvde_pkg::OP_MUL :
                               (f3 == 3'd4) ? rvde_pkg::OP_DIV : rvde_pkg::OP_REM;
                end else begin
                    if (opc == rvde_pkg::OPC_OP && !(f7 == 7'h00 ||
                        (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))) bad = 1'b1;
                    if (opc == rvde_pkg::OPC_OPIMM && f3 == 3'd1 && f6 != 6'h00) bad = 1'b1;
                    if (opc == rvde_pkg::OPC_OPIMM && f3 == 3'd5 && f6 != 6'h00 &&
                        f6 != 6'h10) bad = 1'b1;
                    case (f3)
                        3'd0: o_uop.op = (opc == rvde_pkg::OPC_OP && f7 == 7'h20) ?
                                         rvde_pkg::OP_SUB : rvde_pkg::OP_ADD;
                        3'd1: o_uop.op = rvde_pkg::OP_SLL;
                        3'd2: o_uop.op = rvde_pkg::OP_SLT;
                        3'd3: o_uop.op = rvde_pkg::OP_SLTU;
                        3'd4: o_uop.op = rvde_pkg::OP_XOR;
                        3'd5: o_uop.op = i_instruction[30] ? rvde_pkg::OP_SRA
                                                           : rvde_pkg::OP_SRL;
                        3'd6: o_uop.op = rvde_pkg::OP_OR;
                        default: o_uop.op = rvde_pkg::OP_AND;
                    endcase
                end
            end
            rvde_pkg::OPC_OP32, rvde_pkg::OPC_OPIMM32: begin
                o_uop.src1_reg = rs1;
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                if (opc == rvde_pkg::OPC_OPIMM32) begin
                    o_uop.b = imm_i;
                end else begin
                    o_uop.src2_reg = rs2;
                end
                if (f3 == 3'd0) begin
                    if (opc == rvde_pkg::OPC_OPIMM32 || f7 == 7'h00) o_uop.op = rvde_pkg::OP_ADDW;
                    else if (f7 == 7'h20) o_uop.op = rvde_pkg::OP_SUBW;
                    else bad = 1'b1;
                end else if (f3 == 3'd1 && f7 == 7'h00) begin
                    o_uop.op = rvde_pkg::OP_SLLW;
                end else if (f3 == 3'd5 && f7 == 7'h00) begin
                    o_uop.op = rvde_pkg::OP_SRLW;
                end else if (f3 == 3'd5 && f7 == 7'h20) begin
                    o_uop.op = rvde_pkg::OP_SRAW;
                end else begin
                    bad = 1'b1;
                end
            end
            rvde_pkg::OPC_LUI: begin
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                o_uop.op = rvde_pkg::OP_PASS_B;
                o_uop.b = imm_u;
            end
            rvde_pkg::OPC_AUIPC: begin
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                o_uop.op = rvde_pkg::OP_ADD;
                o_uop.a = {32'd0, i_pc};
                o_uop.b = imm_u;
            end
            rvde_pkg::OPC_JAL: begin
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                o_uop.op = rvde_pkg::OP_LINK;
            end
            rvde_pkg::OPC_JALR: begin
                if (f3 != 3'd0) bad = 1'b1;
                o_uop.src1_reg = rs1;
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                o_uop.op = rvde_pkg::OP_LINK;
                o_uop.jump_target = (i_src1_value[31:0] + imm_i[31:0]) & ~32'd1;
            end
            rvde_pkg::OPC_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) bad = 1'b1;
                o_uop.src1_reg = rs1;
                o_uop.src2_reg = rs2;
                o_uop.op = rvde_pkg::OP_BCOND;
            end
            rvde_pkg::OPC_LOAD: begin
                if (f3 == 3'd7) bad = 1'b1;
                o_uop.src1_reg = rs1;
                o_uop.dst_reg = rd;
                o_uop.writes_dest = 1'b1;
                o_uop.b = imm_i;
                o_uop.mem_kind = rvde_pkg::MEM_LOAD;
                o_uop.access_size = f3[1:0];
                o_uop.load_signed = ~f3[2];
            end
            rvde_pkg::OPC_STORE: begin
                if (f3[2]) bad = 1'b1;
                o_uop.src1_reg = rs1;
                o_uop.src2_reg = rs2;
                o_uop.b = imm_s;
                o_uop.mem_kind = rvde_pkg::MEM_STORE;
                o_uop.access_size = f3[1:0];
                case (f3[1:0])
                    2'd0: o_uop.store_data = {56'd0, i_src2_value[7:0]};
                    2'd1: o_uop.store_data = {48'd0, i_src2_value[15:0]};
                    2'd2: o_uop.store_data = {32'd0, i_src2_value[31:0]};
                    default: o_uop.store_data = i_src2_value;
                endcase
            end
            rvde_pkg::OPC_SYSTEM: begin
                if (i_instruction != rvde_pkg::ECALL_WORD) bad = 1'b1;
                o_uop.src1_reg = rvde_pkg::REG_A0;
                o_uop.src2_reg = rvde_pkg::REG_A7;
                o_uop.dst_reg = rvde_pkg::REG_A0;
                o_uop.writes_dest = 1'b1;
                o_uop.op = rvde_pkg::OP_PASS_A;
                o_uop.status = rvde_pkg::ST_ECALL;
            end
            default: bad = 1'b1;
        endcase
        // Illegal: cleared to a never-taken branch at pc with illegal status, which yields pc+4
        if (bad) begin
            o_uop = '0;
            o_uop.op = rvde_pkg::OP_BCOND;
            o_uop.f3 = 3'd2;
            o_uop.pc = i_pc;
            o_uop.status = rvde_pkg::ST_ILLEGAL;
        end
    end
endmodule

@@ design/rvde_divider.sv @@
// Radix-2 iterative signed divider (quotient and remainder).
`timescale 1ns / 1ps
module rvde_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [64:0] r_r, n_r;
    logic [63:0] r_d, n_d;
    logic        r_nq, n_nq;
    logic        r_nr, n_nr;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {r_r[63:0], r_q[63]};
    assign diff    = shifted - {1'b0, r_d};

    // One quotient bit per cycle; done stays high until the next start
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_nq   = r_nq;
        n_nr   = r_nr;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = 7'd64;
            n_q    = i_a[63] ? (64'd0 - i_a) : i_a;
            n_d    = i_b[63] ? (64'd0 - i_b) : i_b;
            n_r    = '0;
            n_nq   = i_a[63] ^ i_b[63];
            n_nr   = i_a[63];
        end else if (r_busy) begin
            n_q = {r_q[62:0], ~diff[64]};
            n_r = diff[64] ? shifted : diff;
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q  <= n_q;
        r_r  <= n_r;
        r_d  <= n_d;
        r_nq <= n_nq;
        r_nr <= n_nr;
    end

    // Zero divisor gives all ones / dividend; overflow falls out naturally
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = (r_d == 64'd0) ? '1 : (r_nq ? (64'd0 - r_q) : r_q);
    assign o_rem  = r_nr ? (64'd0 - r_r[63:0]) : r_r[63:0];
endmodule

@@ design/rvde_execute.sv @@
// Back end: carries out one classified instruction, stalling on divide.
`timescale 1ns / 1ps
module rvde_execute (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rvde_pkg::t_uop  i_uop,
    output logic            o_valid,
    input  logic            i_ready,
    output rvde_pkg::t_res  o_res
);
    // Stage 1: ALU/branch or multiplier partial products
    logic            r_v1, n_v1;
    rvde_pkg::t_uop  r_u1;
    rvde_pkg::t_res  r_base1;
    logic [63:0]     r_pp_ll, r_pp_lh, r_pp_hl;
    logic            r_div1;
    logic            r_ov;
    // Output register
    logic            r_vo;
    rvde_pkg::t_res  r_out;
    rvde_pkg::t_res  base, fin;
    logic            stall1, adv1, div_wait;
    logic            div_busy, div_done;
    logic [63:0]     div_q, div_r;
    logic            r_div_started;
    logic [5:0]      sh6;
    logic [4:0]      sh5;
    logic [63:0]     a, b, sum, dif;
    logic [31:0]     lo;
    logic            lts, ltu, eq, cond;

    assign a   = i_uop.a;
    assign b   = i_uop.b;
    assign sum = a + b;
    assign dif = a - b;
    assign sh6 = b[5:0];
    assign sh5 = b[4:0];
    assign lo  = a[31:0];
    assign lts = $signed(a) < $signed(b);
    assign ltu = a < b;
    assign eq  = a == b;

    // Combinational ALU, link and branch results
    always_comb begin
        base.src1_reg    = i_uop.src1_reg;
        base.src2_reg    = i_uop.src2_reg;
        base.dst_reg     = i_uop.dst_reg;
        base.writes_dest = i_uop.writes_dest;
        base.mem_kind    = i_uop.mem_kind;
        base.access_size = i_uop.access_size;
        base.load_signed = i_uop.load_signed;
        base.store_data  = i_uop.store_data;
        base.status      = i_uop.status;
        base.taken       = 1'b0;
        base.next_pc     = i_uop.pc + 32'd4;
        base.result      = '0;
        cond = 1'b0;
        case (i_uop.op)
            rvde_pkg::OP_ADD:    base.result = sum;
            rvde_pkg::OP_SUB:    base.result = dif;
            rvde_pkg::OP_SLL:    base.result = a << sh6;
            rvde_pkg::OP_SLT:    base.result = {63'd0, lts};
            rvde_pkg::OP_SLTU:   base.result = {63'd0, ltu};
            rvde_pkg::OP_XOR:    base.result = a ^ b;
            rvde_pkg::OP_SRL:    base.result = a >> sh6;
            rvde_pkg::OP_SRA:    base.result = $signed(a) >>> sh6;
            rvde_pkg::OP_OR:     base.result = a | b;
            rvde_pkg::OP_AND:    base.result = a & b;
            rvde_pkg::OP_ADDW:   base.result = rvde_pkg::sext32(sum[31:0]);
            rvde_pkg::OP_SUBW:   base.result = rvde_pkg::sext32(dif[31:0]);
            rvde_pkg::OP_SLLW:   base.result = rvde_pkg::sext32(lo << sh5);
            rvde_pkg::OP_SRLW:   base.result = rvde_pkg::sext32(lo >> sh5);
            rvde_pkg::OP_SRAW:   base.result = rvde_pkg::sext32($signed(lo) >>> sh5);
            rvde_pkg::OP_PASS_A: base.result = a;
            rvde_pkg::OP_PASS_B: base.result = b;
            rvde_pkg::OP_LINK: begin
                base.result  = {32'd0, i_uop.pc} + 64'd4;
                base.taken   = 1'b1;
                base.next_pc = i_uop.jump_target;
            end
            rvde_pkg::OP_BCOND: begin
                case (i_uop.f3)
                    3'd0: cond = eq;
                    3'd1: cond = !eq;
                    3'd4: cond = lts;
                    3'd5: cond = !lts;
                    3'd6: cond = ltu;
                    3'd7: cond = !ltu;
                    default: cond = 1'b0;
                endcase
                base.taken = cond;
                if (cond) base.next_pc = i_uop.pc + i_uop.branch_off;
            end
            default: base.result = '0;
        endcase
    end

    // Stage 1 holds when the output register is full and not taken, or a divide runs
    assign div_wait = r_v1 && r_div1 && !(r_div_started && div_done);
    assign stall1   = r_v1 && (div_wait || (r_vo && !i_ready));
    assign o_ready  = !stall1;
    assign adv1     = r_v1 && !stall1;

    always_comb begin
        n_v1 = r_v1;
        if (o_ready) n_v1 = i_valid;
    end

    rvde_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_v1 && r_div1 && !r_div_started && !div_busy),
        .i_a     (r_u1.a),
        .i_b     (r_u1.b),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_div_started <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            if (o_ready) r_div_started <= 1'b0;
            else if (r_v1 && r_div1 && !div_busy) r_div_started <= 1'b1;
        end
        if (o_ready && i_valid) begin
            r_u1    <= i_uop;
            r_base1 <= base;
            r_pp_ll <= a[31:0] * b[31:0];
            r_pp_lh <= a[31:0] * b[63:32];
            r_pp_hl <= a[63:32] * b[31:0];
            r_div1  <= (i_uop.op == rvde_pkg::OP_DIV) || (i_uop.op == rvde_pkg::OP_REM);
            r_ov    <= (a == 64'h8000_0000_0000_0000) && (b == '1);
        end
    end

    // Final result selection
    always_comb begin
        fin = r_base1;
        case (r_u1.op)
            rvde_pkg::OP_MUL:
                fin.result = r_pp_ll + {r_pp_lh[31:0], 32'd0} + {r_pp_hl[31:0], 32'd0};
            rvde_pkg::OP_DIV: fin.result = r_ov ? r_u1.a : div_q;
            rvde_pkg::OP_REM: fin.result = r_ov ? 64'd0 : div_r;
            default: fin.result = r_base1.result;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv1) begin
            r_vo <= 1'b1;
        end else if (i_ready) begin
            r_vo <= 1'b0;
        end
        if (adv1) r_out <= fin;
    end

    assign o_valid = r_vo;
    assign o_res   = r_out;

    // A divide never leaves stage 1 before the divider reports done
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && r_div1) |-> div_done) else $error("divide retired early");
    // Stalled output holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_ready) |=> (r_vo && $stable(r_out))) else $error("output lost");
    // Divider is busy only while stage 1 holds an item
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> r_v1) else $error("divider busy with no item");
endmodule

@@ design/rv64im_decode_execute.sv @@
// Top level: RV64IM decode/execute with a two-entry queue between halves.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_*: one instruction per transaction, tdata holds
//   instruction, pc, src1_value, src2_value from the lowest bit up.
//   Master channel m_axis_*: one result per instruction, same order.
//   Path: decode writes a 2-entry queue, then execute stage 1, then the
//   output register, each of them registered.
//   Throughput: one instruction per cycle; DIV and REM hold execute stage 1
//   until the radix-2 divider, at one quotient bit per cycle over 64 bits,
//   reports done.
//   Multiply is split into 32x32 partial products, summed one stage later.
//   Reset (i_rst_n low, synchronous) empties the queue and all stages.
//   When the receiver stalls, the output register holds, the execute
//   stage fills, then the queue, and s_axis_tready falls.
module rv64im_decode_execute (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction[31:0], pc[63:32], src1_value[127:64], src2_value[191:128]
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // src1_reg[4:0], src2_reg[9:5], dst_reg[14:10], writes_dest[15],
    // result[79:16], taken[80], next_pc[112:81], mem_kind[114:113],
    // access_size[116:115], load_signed[117], store_data[181:118],
    // status[183:182], 184 bits in all
    output logic [183:0] m_axis_tdata
);
    rvde_pkg::t_uop dec_uop;
    rvde_pkg::t_uop r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           q_push, q_pop, ex_ready;
    rvde_pkg::t_res res;

    rvde_decode u_dec (
        .i_instruction (s_axis_tdata[31:0]),
        .i_pc          (s_axis_tdata[63:32]),
        .i_src1_value  (s_axis_tdata[127:64]),
        .i_src2_value  (s_axis_tdata[191:128]),
        .o_uop         (dec_uop)
    );

    // Decoupling queue
    assign s_axis_tready = (r_cnt != 2'd2);
    assign q_push = s_axis_tvalid && s_axis_tready;
    assign q_pop  = (r_cnt != 2'd0) && ex_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (q_push) r_wp <= ~r_wp;
            if (q_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, q_push} - {1'b0, q_pop};
        end
        if (q_push) r_q[r_wp] <= dec_uop;
    end

    rvde_execute u_ex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cnt != 2'd0),
        .o_ready (ex_ready),
        .i_uop   (r_q[r_rp]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {res.status, res.store_data, res.load_signed, res.access_size,
                           res.mem_kind, res.next_pc, res.taken, res.result,
                           res.writes_dest, res.dst_reg, res.src2_reg, res.src1_reg};

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_q_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready) else $error("accept while full");
    a_q_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd0) || (r_cnt == 2'd2)) |-> (r_wp == r_rp)) else $error("queue pointers");
endmodule
